@@ rtl/fspc_pkg.sv @@
// Shared types, constants and instruction field helpers for the pipelined core.
// No dependencies; used by the top level.
`default_nettype none
package fspc_pkg;

    localparam int ADDR_W    = 16;
    localparam int MEM_WORDS = 1 << ADDR_W;
    localparam int REG_COUNT = 8;
    localparam int REG_W     = $clog2(REG_COUNT);

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_NOR  = 3'd1,
        OP_LW   = 3'd2,
        OP_SW   = 3'd3,
        OP_BEQ  = 3'd4,
        OP_JALR = 3'd5,
        OP_HALT = 3'd6,
        OP_NOOP = 3'd7
    } opcode_t;

    localparam logic [31:0] NOOP_WORD = {7'd0, OP_NOOP, 22'd0};

    function automatic opcode_t opc(input logic [31:0] w);
        return opcode_t'(w[24:22]);
    endfunction

    function automatic logic [REG_W-1:0] rega(input logic [31:0] w);
        return w[21:19];
    endfunction

    function automatic logic [REG_W-1:0] regb(input logic [31:0] w);
        return w[18:16];
    endfunction

    function automatic logic has_dest(input logic [31:0] w);
        return (opc(w) == OP_LW) || (opc(w) == OP_ADD) || (opc(w) == OP_NOR);
    endfunction

    function automatic logic [REG_W-1:0] dest(input logic [31:0] w);
        return (opc(w) == OP_LW) ? w[18:16] : w[2:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/fspc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module fspc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/five_stage_pipeline_core_unit.sv @@
// Top level of the five-stage pipelined core with its beat handshakes.
// Depends on fspc_pkg and fspc_ram.
`default_nettype none
// Each beat either loads one word into both memories or runs one clock tick of
// the core, and yields one result beat. A beat is taken every cycle unless an
// unaccepted result beat holds the input: the whole tick runs between the
// pipeline latch registers and the result register, and both memories are read
// ahead at the next fetch and data address. After reset the memories are cleared
// one word per cycle, so the input is not ready until all 65536 words are clear.
module five_stage_pipeline_core_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [15:0] s_load_address,
    input  wire logic [31:0] s_load_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_halted,
    output logic [15:0]      m_program_counter,
    output logic [31:0]      m_cycle_count,
    output logic             m_writeback_enable,
    output logic [2:0]       m_writeback_register,
    output logic [31:0]      m_writeback_value,
    output logic             m_store_enable,
    output logic [15:0]      m_store_address,
    output logic [31:0]      m_store_value
);

    localparam int AW = fspc_pkg::ADDR_W;
    localparam int RC = fspc_pkg::REG_COUNT;
    localparam int RW = fspc_pkg::REG_W;

    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic [AW-1:0] fa_reg, fa_next;
    logic [31:0]   tick_reg, tick_next;
    logic [31:0]   rf_reg [RC];
    logic [31:0]   rf_next [RC];
    logic [31:0]   fd_instr_reg, fd_instr_next;
    logic [AW-1:0] fd_pc1_reg, fd_pc1_next;
    logic [31:0]   de_instr_reg, de_instr_next;
    logic [AW-1:0] de_pc1_reg, de_pc1_next;
    logic [31:0]   de_va_reg, de_va_next, de_vb_reg, de_vb_next, de_off_reg, de_off_next;
    logic [31:0]   em_instr_reg, em_instr_next;
    logic [AW-1:0] em_target_reg, em_target_next;
    logic          em_eq_reg, em_eq_next;
    logic [31:0]   em_alu_reg, em_alu_next, em_vb_reg, em_vb_next;
    logic [31:0]   mw_instr_reg, mw_instr_next, mw_data_reg, mw_data_next;
    logic [31:0]   we_instr_reg, we_instr_next, we_data_reg, we_data_next;

    logic          m_valid_reg;
    logic          s_fire, tick_go, load_go, halt_now, hazard, taken;
    logic [31:0]   fwd_a, fwd_b;
    logic          wb_en;
    logic [RW-1:0] wb_reg;
    logic [31:0]   wb_val;
    logic          st_en;
    logic [AW-1:0] st_addr;
    logic [31:0]   st_val;

    logic          im_we, dm_we;
    logic [AW-1:0] im_waddr, dm_waddr;
    logic [31:0]   im_wdata, dm_wdata, im_rdata, dm_rdata, im_q, dm_q;
    logic          im_hit_reg, dm_hit_reg;
    logic [31:0]   im_wd_reg, dm_wd_reg;

    assign halt_now = fspc_pkg::opc(mw_instr_reg) == fspc_pkg::OP_HALT;
    assign s_ready  = !clr_busy_reg && (!m_valid_reg || m_ready);
    assign s_fire   = s_valid && s_ready;
    assign load_go  = s_fire && !s_action;
    assign tick_go  = s_fire && s_action && !halt_now;
    assign m_valid  = m_valid_reg;

    assign im_q = im_hit_reg ? im_wd_reg : im_rdata;
    assign dm_q = dm_hit_reg ? dm_wd_reg : dm_rdata;

    always_comb begin
        fa_next = fa_reg;
        tick_next = tick_reg;
        for (int i = 0; i < RC; i++) begin
            rf_next[i] = rf_reg[i];
        end
        fd_instr_next = fd_instr_reg;
        fd_pc1_next = fd_pc1_reg;
        de_instr_next = de_instr_reg;
        de_pc1_next = de_pc1_reg;
        de_va_next = de_va_reg;
        de_vb_next = de_vb_reg;
        de_off_next = de_off_reg;
        em_instr_next = em_instr_reg;
        em_target_next = em_target_reg;
        em_eq_next = em_eq_reg;
        em_alu_next = em_alu_reg;
        em_vb_next = em_vb_reg;
        mw_instr_next = mw_instr_reg;
        mw_data_next = mw_data_reg;
        we_instr_next = we_instr_reg;
        we_data_next = we_data_reg;
        wb_en = 1'b0;
        wb_reg = '0;
        wb_val = '0;
        st_en = 1'b0;
        st_addr = '0;
        st_val = '0;
        hazard = 1'b0;
        taken = 1'b0;
        fwd_a = de_va_reg;
        fwd_b = de_vb_reg;
        if (tick_go) begin
            tick_next = tick_reg + 32'd1;

            fd_instr_next = im_q;
            fd_pc1_next = fa_reg + AW'(1);
            fa_next = fa_reg + AW'(1);

            de_instr_next = fd_instr_reg;
            de_pc1_next = fd_pc1_reg;
            de_va_next = rf_reg[fspc_pkg::rega(fd_instr_reg)];
            de_vb_next = rf_reg[fspc_pkg::regb(fd_instr_reg)];
            de_off_next = {{16{fd_instr_reg[15]}}, fd_instr_reg[15:0]};
            if (fspc_pkg::opc(de_instr_reg) == fspc_pkg::OP_LW) begin
                if (fspc_pkg::opc(fd_instr_reg) == fspc_pkg::OP_LW) begin
                    hazard = fspc_pkg::rega(fd_instr_reg) == fspc_pkg::regb(de_instr_reg);
                end else if (fspc_pkg::opc(fd_instr_reg) <= fspc_pkg::OP_BEQ) begin
                    hazard = (fspc_pkg::rega(fd_instr_reg) == fspc_pkg::regb(de_instr_reg))
                          || (fspc_pkg::regb(fd_instr_reg) == fspc_pkg::regb(de_instr_reg));
                end
            end
            if (hazard) begin
                de_instr_next = fspc_pkg::NOOP_WORD;
                fa_next = fa_reg;
                fd_instr_next = fd_instr_reg;
                fd_pc1_next = fd_pc1_reg;
            end

            if (fspc_pkg::opc(de_instr_reg) <= fspc_pkg::OP_BEQ) begin
                if (fspc_pkg::has_dest(we_instr_reg)) begin
                    if (fspc_pkg::rega(de_instr_reg) == fspc_pkg::dest(we_instr_reg)) begin
                        fwd_a = we_data_reg;
                    end
                    if (fspc_pkg::regb(de_instr_reg) == fspc_pkg::dest(we_instr_reg)) begin
                        fwd_b = we_data_reg;
                    end
                end
                if (fspc_pkg::has_dest(mw_instr_reg)) begin
                    if (fspc_pkg::rega(de_instr_reg) == fspc_pkg::dest(mw_instr_reg)) begin
                        fwd_a = mw_data_reg;
                    end
                    if (fspc_pkg::regb(de_instr_reg) == fspc_pkg::dest(mw_instr_reg)) begin
                        fwd_b = mw_data_reg;
                    end
                end
                if (fspc_pkg::has_dest(em_instr_reg)) begin
                    if (fspc_pkg::rega(de_instr_reg) == fspc_pkg::dest(em_instr_reg)) begin
                        fwd_a = em_alu_reg;
                    end
                    if (fspc_pkg::regb(de_instr_reg) == fspc_pkg::dest(em_instr_reg)) begin
                        fwd_b = em_alu_reg;
                    end
                end
            end
            em_instr_next = de_instr_reg;
            em_vb_next = fwd_b;
            em_target_next = de_off_reg[AW-1:0] + de_pc1_reg;
            em_eq_next = fwd_a == fwd_b;
            unique case (fspc_pkg::opc(de_instr_reg)) inside
                fspc_pkg::OP_LW, fspc_pkg::OP_SW: em_alu_next = fwd_a + de_off_reg;
                fspc_pkg::OP_NOR: em_alu_next = ~(fwd_a | fwd_b);
                fspc_pkg::OP_ADD: em_alu_next = fwd_a + fwd_b;
                default: em_alu_next = em_alu_reg;
            endcase

            mw_instr_next = em_instr_reg;
            mw_data_next = em_alu_reg;
            if (fspc_pkg::opc(em_instr_reg) == fspc_pkg::OP_BEQ && em_eq_reg) begin
                taken = 1'b1;
                fa_next = em_target_reg;
                fd_instr_next = fspc_pkg::NOOP_WORD;
                de_instr_next = fspc_pkg::NOOP_WORD;
                em_instr_next = fspc_pkg::NOOP_WORD;
            end else if (fspc_pkg::opc(em_instr_reg) == fspc_pkg::OP_LW
                      || fspc_pkg::opc(em_instr_reg) == fspc_pkg::OP_SW) begin
                mw_data_next = dm_q;
                if (fspc_pkg::opc(em_instr_reg) == fspc_pkg::OP_SW) begin
                    st_en = 1'b1;
                    st_addr = em_alu_reg[AW-1:0];
                    st_val = em_vb_reg;
                end
            end

            we_instr_next = mw_instr_reg;
            we_data_next = mw_data_reg;
            if (fspc_pkg::has_dest(mw_instr_reg)) begin
                rf_next[fspc_pkg::dest(mw_instr_reg)] = mw_data_reg;
                wb_en = 1'b1;
                wb_reg = fspc_pkg::dest(mw_instr_reg);
                wb_val = mw_data_reg;
            end
        end
    end

    always_comb begin
        im_we = clr_busy_reg || load_go;
        im_waddr = clr_busy_reg ? clr_cnt_reg : s_load_address;
        im_wdata = clr_busy_reg ? 32'd0 : s_load_word;
        dm_we = clr_busy_reg || load_go || st_en;
        dm_waddr = clr_busy_reg ? clr_cnt_reg : (st_en ? st_addr : s_load_address);
        dm_wdata = clr_busy_reg ? 32'd0 : (st_en ? st_val : s_load_word);
    end

    fspc_ram #(.WIDTH(32), .DEPTH(fspc_pkg::MEM_WORDS)) u_imem (
        .clk   (aclk),
        .we    (im_we),
        .waddr (im_waddr),
        .wdata (im_wdata),
        .raddr (fa_next),
        .rdata (im_rdata)
    );

    fspc_ram #(.WIDTH(32), .DEPTH(fspc_pkg::MEM_WORDS)) u_dmem (
        .clk   (aclk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (em_alu_next[AW-1:0]),
        .rdata (dm_rdata)
    );

    always_ff @(posedge aclk) begin
        im_hit_reg <= im_we && (im_waddr == fa_next);
        im_wd_reg <= im_wdata;
        dm_hit_reg <= dm_we && (dm_waddr == em_alu_next[AW-1:0]);
        dm_wd_reg <= dm_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            fa_reg <= '0;
            tick_reg <= '0;
            for (int i = 0; i < RC; i++) begin
                rf_reg[i] <= '0;
            end
            fd_instr_reg <= fspc_pkg::NOOP_WORD;
            fd_pc1_reg <= '0;
            de_instr_reg <= fspc_pkg::NOOP_WORD;
            de_pc1_reg <= '0;
            de_va_reg <= '0;
            de_vb_reg <= '0;
            de_off_reg <= '0;
            em_instr_reg <= fspc_pkg::NOOP_WORD;
            em_target_reg <= '0;
            em_eq_reg <= 1'b0;
            em_alu_reg <= '0;
            em_vb_reg <= '0;
            mw_instr_reg <= fspc_pkg::NOOP_WORD;
            mw_data_reg <= '0;
            we_instr_reg <= fspc_pkg::NOOP_WORD;
            we_data_reg <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(fspc_pkg::MEM_WORDS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            fa_reg <= fa_next;
            tick_reg <= tick_next;
            for (int i = 0; i < RC; i++) begin
                rf_reg[i] <= rf_next[i];
            end
            fd_instr_reg <= fd_instr_next;
            fd_pc1_reg <= fd_pc1_next;
            de_instr_reg <= de_instr_next;
            de_pc1_reg <= de_pc1_next;
            de_va_reg <= de_va_next;
            de_vb_reg <= de_vb_next;
            de_off_reg <= de_off_next;
            em_instr_reg <= em_instr_next;
            em_target_reg <= em_target_next;
            em_eq_reg <= em_eq_next;
            em_alu_reg <= em_alu_next;
            em_vb_reg <= em_vb_next;
            mw_instr_reg <= mw_instr_next;
            mw_data_reg <= mw_data_next;
            we_instr_reg <= we_instr_next;
            we_data_reg <= we_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_halted <= fspc_pkg::opc(mw_instr_next) == fspc_pkg::OP_HALT;
            m_program_counter <= fa_next;
            m_cycle_count <= tick_next;
            m_writeback_enable <= wb_en;
            m_writeback_register <= wb_reg;
            m_writeback_value <= wb_val;
            m_store_enable <= st_en;
            m_store_address <= st_addr;
            m_store_value <= st_val;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk)
        clr_busy_reg |-> !s_ready) else $error("beat accepted during memory clear");
    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_now |=> halt_now) else $error("halt left the MEM/WB latch");
    a_branch_squash: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_go && taken) |=> (fspc_pkg::opc(em_instr_reg) == fspc_pkg::OP_NOOP
            && fspc_pkg::opc(de_instr_reg) == fspc_pkg::OP_NOOP))
        else $error("taken branch did not squash younger stages");
    a_stall_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_go && hazard && !taken) |=> (fspc_pkg::opc(de_instr_reg) == fspc_pkg::OP_NOOP
            && fa_reg == $past(fa_reg)))
        else $error("load-use stall did not insert a bubble");
`endif

endmodule
`default_nettype wire
